// ===== design/sdhs_pkg.sv =====
// Package for the string dedup hash set: sizes, beat types, codes, control structs.
`default_nettype none
package sdhs_pkg;

    localparam int TABLE_SLOTS    = 1024;
    localparam int MAX_UNIQUE     = 512;
    localparam int MAX_WORD_BYTES = 24;
    localparam int HASH_INIT      = 5381;

    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int IDX_W   = (MAX_UNIQUE > 1) ? $clog2(MAX_UNIQUE) : 1;
    localparam int TOT_W   = $clog2(MAX_UNIQUE + 1);
    localparam int LEN_W   = $clog2(MAX_WORD_BYTES + 1);
    localparam int J_W     = (MAX_WORD_BYTES > 1) ? $clog2(MAX_WORD_BYTES) : 1;
    localparam int STORE_D = MAX_UNIQUE * MAX_WORD_BYTES;
    localparam int STORE_AW = (STORE_D > 1) ? $clog2(STORE_D) : 1;

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        ST_NEW  = 2'd0,
        ST_DUP  = 2'd1,
        ST_LONG = 2'd2,
        ST_FULL = 2'd3
    } t_status;

    typedef struct packed {
        logic       op;
        logic [7:0] word_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [1:0] status;
        logic [8:0] entry_index;
        logic [9:0] unique_count;
    } t_out_beat;

    typedef struct packed {
        logic           vld;
        logic [IDX_W-1:0] idx;
    } t_slot;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_WAIT, S_SLOT, S_LEN, S_CMP, S_INSERT
    } t_state;

    typedef struct packed {
        logic    take_byte;
        logic    word_clr;
        logic    set_clear;
        logic    clr_step;
        logic    probe_init;
        logic    next_slot;
        logic    j_inc;
        logic    cmp_mode;
        logic    ins_write;
        logic    ins_fin;
        logic    emit;
        t_status emit_status;
    } t_cmd;

    typedef struct packed {
        logic ends_long;
        logic slot_vld;
        logic len_match;
        logic byte_match;
        logic cmp_last;
        logic ins_last;
        logic probe_done;
        logic store_full;
        logic clr_done;
        logic out_valid;
    } t_stat;

endpackage
`default_nettype wire

// ===== design/sdhs_dpath.sv =====
// Datapath: hash, current word, slot table, word store, length store, result register.
`default_nettype none
module sdhs_dpath import sdhs_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_beat  i_beat,
    input  wire t_cmd      i_cmd,
    input  wire logic      i_out_ready,
    output t_stat          o_stat,
    output t_out_beat      o_out_data,
    output logic           o_out_valid
);

    t_slot      slot_mem [TABLE_SLOTS];
    logic [7:0] store_mem [STORE_D];
    logic [LEN_W-1:0] len_mem [MAX_UNIQUE];
    logic [7:0] r_word [MAX_WORD_BYTES];

    logic [SLOT_W-1:0] r_hash, n_hash, r_k, r_n, r_clr;
    logic [LEN_W-1:0]  r_len, r_len_q;
    logic [TOT_W-1:0]  r_total;
    logic              r_overlong, r_ovalid;
    logic [J_W-1:0]    r_j, r_jd, word_ra;
    t_slot             r_slot_q, slot_wd;
    logic [SLOT_W-1:0] slot_wa;
    logic              slot_we;
    logic [7:0]        r_byte_q, cur_byte;
    logic [IDX_W-1:0]  tot_idx;
    logic [STORE_AW-1:0] st_ra, st_wa;
    t_out_beat         r_out;

    assign n_hash  = SLOT_W'((r_hash << 5) + r_hash + SLOT_W'(i_beat.word_byte));
    assign tot_idx = IDX_W'(r_total);
    assign word_ra = i_cmd.cmp_mode ? r_jd : r_j;
    assign cur_byte = r_word[word_ra];
    assign st_ra = STORE_AW'(STORE_AW'(r_slot_q.idx) * STORE_AW'(MAX_WORD_BYTES))
                   + STORE_AW'(r_j);
    assign st_wa = STORE_AW'(STORE_AW'(tot_idx) * STORE_AW'(MAX_WORD_BYTES))
                   + STORE_AW'(r_j);

    always_comb begin
        slot_we = i_cmd.clr_step | i_cmd.ins_fin;
        slot_wa = i_cmd.clr_step ? r_clr : r_k;
        slot_wd.vld = ~i_cmd.clr_step;
        slot_wd.idx = tot_idx;
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[slot_wa] <= slot_wd;
        end
        r_slot_q <= slot_mem[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_write) begin
            store_mem[st_wa] <= cur_byte;
        end
        r_byte_q <= store_mem[st_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_fin) begin
            len_mem[tot_idx] <= r_len;
        end
        r_len_q <= len_mem[r_slot_q.idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_byte && r_len < LEN_W'(MAX_WORD_BYTES)) begin
            r_word[r_len[J_W-1:0]] <= i_beat.word_byte;
        end
        r_jd <= r_j;
        if (i_cmd.probe_init) begin
            r_k <= n_hash;
            r_n <= '0;
            r_j <= '0;
        end else if (i_cmd.next_slot) begin
            r_k <= r_k + SLOT_W'(1);
            r_n <= r_n + SLOT_W'(1);
            r_j <= '0;
        end else if (i_cmd.j_inc && r_j != J_W'(MAX_WORD_BYTES - 1)) begin
            r_j <= r_j + J_W'(1);
        end
        if (i_cmd.emit) begin
            r_out.status <= i_cmd.emit_status;
            case (i_cmd.emit_status)
                ST_NEW:  r_out.entry_index <= 9'(tot_idx);
                ST_DUP:  r_out.entry_index <= 9'(r_slot_q.idx);
                default: r_out.entry_index <= '0;
            endcase
            r_out.unique_count <= (i_cmd.emit_status == ST_NEW)
                                  ? 10'(r_total + TOT_W'(1)) : 10'(r_total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash     <= SLOT_W'(HASH_INIT % TABLE_SLOTS);
            r_len      <= '0;
            r_overlong <= 1'b0;
            r_total    <= '0;
            r_ovalid   <= 1'b0;
            r_clr      <= '0;
        end else begin
            if (i_cmd.word_clr) begin
                r_hash     <= SLOT_W'(HASH_INIT % TABLE_SLOTS);
                r_len      <= '0;
                r_overlong <= 1'b0;
            end else if (i_cmd.take_byte) begin
                r_hash <= n_hash;
                if (r_len < LEN_W'(MAX_WORD_BYTES)) begin
                    r_len <= r_len + LEN_W'(1);
                end else begin
                    r_overlong <= 1'b1;
                end
            end
            if (i_cmd.set_clear) begin
                r_total <= '0;
                r_clr   <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr <= r_clr + SLOT_W'(1);
            end
            if (i_cmd.ins_fin) begin
                r_total <= r_total + TOT_W'(1);
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.ends_long  = r_overlong | (r_len == LEN_W'(MAX_WORD_BYTES));
        o_stat.slot_vld   = r_slot_q.vld;
        o_stat.len_match  = (r_len_q == r_len);
        o_stat.byte_match = (r_byte_q == cur_byte);
        o_stat.cmp_last   = (LEN_W'(r_jd) + LEN_W'(1) == r_len);
        o_stat.ins_last   = (LEN_W'(r_j) + LEN_W'(1) == r_len);
        o_stat.probe_done = (r_n == SLOT_W'(TABLE_SLOTS - 1));
        o_stat.store_full = (r_total >= TOT_W'(MAX_UNIQUE));
        o_stat.clr_done   = (r_clr == SLOT_W'(TABLE_SLOTS - 1));
        o_stat.out_valid  = r_ovalid;
    end

    assign o_out_data  = r_out;
    assign o_out_valid = r_ovalid;

    a_emit_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !r_ovalid) else $error("result overwritten");
    a_total_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TOT_W'(MAX_UNIQUE)) else $error("unique total beyond store");
    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_fin |-> r_total < TOT_W'(MAX_UNIQUE)) else $error("insert when full");
    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(MAX_WORD_BYTES)) else $error("word length overflow");

endmodule
`default_nettype wire

// ===== design/sdhs_ctrl.sv =====
// Controller: byte intake, probe sequencing, insert, clearing sweep.
`default_nettype none
module sdhs_ctrl import sdhs_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_in_beat i_beat,
    input  wire t_stat    i_stat,
    output logic          o_in_ready,
    output t_cmd          o_cmd
);

    t_state r_state, n_state;
    logic   acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.emit_status = ST_NEW;
        o_in_ready = 1'b0;
        acc        = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = !(i_stat.out_valid && i_beat.op == OP_BYTE && i_beat.last_byte);
                acc = o_in_ready & i_in_valid;
                if (acc) begin
                    if (i_beat.op == OP_CLEAR) begin
                        o_cmd.word_clr  = 1'b1;
                        o_cmd.set_clear = 1'b1;
                        n_state = S_CLEAR;
                    end else if (!i_beat.last_byte) begin
                        o_cmd.take_byte = 1'b1;
                    end else if (i_stat.ends_long) begin
                        o_cmd.word_clr = 1'b1;
                        o_cmd.emit = 1'b1;
                        o_cmd.emit_status = ST_LONG;
                    end else begin
                        o_cmd.take_byte  = 1'b1;
                        o_cmd.probe_init = 1'b1;
                        n_state = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                n_state = S_SLOT;
            end
            S_SLOT: begin
                if (i_stat.slot_vld) begin
                    n_state = S_LEN;
                end else if (i_stat.store_full) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_status = ST_FULL;
                    o_cmd.word_clr = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_INSERT;
                end
            end
            S_LEN: begin
                if (i_stat.len_match) begin
                    o_cmd.j_inc = 1'b1;
                    n_state = S_CMP;
                end else if (i_stat.probe_done) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_status = ST_FULL;
                    o_cmd.word_clr = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.next_slot = 1'b1;
                    n_state = S_WAIT;
                end
            end
            S_CMP: begin
                o_cmd.cmp_mode = 1'b1;
                if (i_stat.byte_match && i_stat.cmp_last) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_status = ST_DUP;
                    o_cmd.word_clr = 1'b1;
                    n_state = S_IDLE;
                end else if (i_stat.byte_match) begin
                    o_cmd.j_inc = 1'b1;
                end else if (i_stat.probe_done) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_status = ST_FULL;
                    o_cmd.word_clr = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.next_slot = 1'b1;
                    n_state = S_WAIT;
                end
            end
            S_INSERT: begin
                o_cmd.ins_write = 1'b1;
                if (i_stat.ins_last) begin
                    o_cmd.ins_fin = 1'b1;
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_status = ST_NEW;
                    o_cmd.word_clr = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.j_inc = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> r_state == S_IDLE) else $error("no return to idle after result");
    a_clear_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.set_clear |=> r_state == S_CLEAR) else $error("clear without sweep");

endmodule
`default_nettype wire

// ===== design/string_dedup_hash_set_core.sv =====
// Top level of the string dedup hash set: controller plus datapath.
// Input channel (i_in_valid/o_in_ready/i_in_data): one beat per word byte, the
// last byte of each word marked; op clear empties the set and drops any partial word.
// Output channel (o_out_valid/i_out_ready/o_out_data): one beat per word end with
// status, entry index and unique count; clear and non-final bytes give no beat.
// Non-final bytes are taken one per cycle while the controller is idle. At a word end
// the probe reads each slot visited (S_WAIT, S_SLOT), checks the stored length of
// each occupied slot (S_LEN) and, if the lengths are equal, compares the stored
// word byte by byte (S_CMP); a new word is then copied byte by byte (S_INSERT).
// The result appears the cycle after the word's decision; an overlong word
// answers the cycle after its last byte. Sequencing is set by the one-port
// slot table read and the byte-at-a-time store compare.
// After reset and after every clear the slot table is swept, one slot a cycle;
// no beat is taken during the sweep.
// A finished result waits in the output register while further bytes are taken;
// only a word-ending byte waits until that result has been taken.
`default_nettype none
module string_dedup_hash_set_core import sdhs_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_beat  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_beat      o_out_data
);

    t_cmd  cmd;
    t_stat stat;

    sdhs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_beat     (i_in_data),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    sdhs_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat      (i_in_data),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_out_data  (o_out_data),
        .o_out_valid (o_out_valid)
    );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for the string dedup hash set: directed and random words, scoreboard check.
`default_nettype none
module tb_top;
    import sdhs_pkg::*;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_beat  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_beat o_out_data;

    string_dedup_hash_set_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic             slot_used [TABLE_SLOTS];
    logic [8:0]       slot_idx  [TABLE_SLOTS];
    logic [7:0]       uniq_bytes [MAX_UNIQUE][MAX_WORD_BYTES];
    int               uniq_len  [MAX_UNIQUE];
    logic [7:0]       cur_bytes [MAX_WORD_BYTES];
    int               cur_len;
    logic [9:0]       djb2_hash;
    int               n_unique;
    logic             too_long;

    t_out_beat expected_words[$];
    int        n_errors;
    int        n_mismatch;
    bit        hold_rx;
    bit        rx_fast;
    int        stall_max = 15;
    int        gap_max = 15;

    // small pool of known words to make duplicates common
    logic [7:0] pool_bytes [64][MAX_WORD_BYTES];
    int         pool_len   [64];

    function automatic void restart_word();
        cur_len   = 0;
        djb2_hash = 10'(HASH_INIT % TABLE_SLOTS);
        too_long  = 1'b0;
    endfunction

    function automatic void clear_model();
        for (int s = 0; s < TABLE_SLOTS; s++) slot_used[s] = 1'b0;
        n_unique = 0;
        restart_word();
    endfunction

    function automatic bit word_matches(int idx);
        if (uniq_len[idx] != cur_len) return 1'b0;
        for (int j = 0; j < cur_len; j++)
            if (uniq_bytes[idx][j] != cur_bytes[j]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void dedup_predict(t_in_beat b);
        t_out_beat r;
        int k;
        int n;
        if (b.op == OP_CLEAR) begin
            clear_model();
            return;
        end
        djb2_hash = 10'(djb2_hash * 33 + b.word_byte);
        if (cur_len < MAX_WORD_BYTES) begin
            cur_bytes[cur_len] = b.word_byte;
            cur_len++;
        end else begin
            too_long = 1'b1;
        end
        if (!b.last_byte) return;
        r = '0;
        r.unique_count = 10'(n_unique);
        if (too_long) begin
            r.status = ST_LONG;
            expected_words.push_back(r);
            restart_word();
            return;
        end
        k = djb2_hash;
        for (n = 0; n < TABLE_SLOTS; n++) begin
            if (!slot_used[k]) break;
            if (word_matches(slot_idx[k])) begin
                r.status = ST_DUP;
                r.entry_index = slot_idx[k];
                expected_words.push_back(r);
                restart_word();
                return;
            end
            k = (k + 1) % TABLE_SLOTS;
        end
        if (n >= TABLE_SLOTS || n_unique >= MAX_UNIQUE) begin
            r.status = ST_FULL;
        end else begin
            slot_used[k] = 1'b1;
            slot_idx[k]  = 9'(n_unique);
            for (int j = 0; j < cur_len; j++) uniq_bytes[n_unique][j] = cur_bytes[j];
            uniq_len[n_unique] = cur_len;
            r.status = ST_NEW;
            r.entry_index = 9'(n_unique);
            n_unique++;
            r.unique_count = 10'(n_unique);
        end
        expected_words.push_back(r);
        restart_word();
    endfunction

    task automatic send_beat(logic op, logic [7:0] b, logic last);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_data  <= '{op: op, word_byte: b, last_byte: last};
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        dedup_predict('{op: op, word_byte: b, last_byte: last});
        @(negedge i_clk);
    endtask

    task automatic send_word(logic [7:0] bytes [MAX_WORD_BYTES], int len);
        for (int j = 0; j < len; j++)
            send_beat(OP_BYTE, (j < MAX_WORD_BYTES) ? bytes[j] : 8'($urandom),
                      j == len - 1);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (50) @(negedge i_clk);
    endtask

    task automatic send_random_word(int maxlen);
        logic [7:0] w [MAX_WORD_BYTES];
        int len;
        len = $urandom_range(1, maxlen);
        for (int j = 0; j < MAX_WORD_BYTES; j++) w[j] = 8'($urandom);
        send_word(w, len);
    endtask

    // receiver
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                n_errors++;
                if (n_mismatch++ < 10) $display("unexpected beat %h", o_out_data);
            end else begin
                t_out_beat e;
                e = expected_words.pop_front();
                if (e.status != o_out_data.status || e.entry_index != o_out_data.entry_index
                    || e.unique_count != o_out_data.unique_count) begin
                    n_errors++;
                    if (n_mismatch++ < 10)
                        $display("mismatch: exp st=%0d idx=%0d cnt=%0d got st=%0d idx=%0d cnt=%0d",
                                 e.status, e.entry_index, e.unique_count,
                                 o_out_data.status, o_out_data.entry_index,
                                 o_out_data.unique_count);
                end
            end
        end
    end

    initial begin : rx_ready
        int w;
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                i_out_ready <= 1'b0;
            end else if (rx_fast) begin
                i_out_ready <= 1'b1;
            end else begin
                w = $urandom_range(0, stall_max);
                if (w > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (w) @(negedge i_clk);
                end
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic test_directed();
        logic [7:0] w [MAX_WORD_BYTES];
        for (int j = 0; j < MAX_WORD_BYTES; j++) w[j] = 8'hFF;
        send_word(w, 1);
        send_word(w, 1);
        send_word(w, MAX_WORD_BYTES);
        send_word(w, MAX_WORD_BYTES + 1);
        for (int j = 0; j < MAX_WORD_BYTES; j++) w[j] = 8'h00;
        send_word(w, 1);
        send_word(w, 2);
        send_word(w, MAX_WORD_BYTES);
        send_word(w, MAX_WORD_BYTES);
        for (int j = 0; j < MAX_WORD_BYTES; j++) w[j] = 8'(j * 37 + 1);
        send_word(w, 5);
        send_beat(OP_BYTE, 8'h41, 1'b0);
        send_beat(OP_BYTE, 8'h42, 1'b0);
        send_beat(OP_CLEAR, 8'hAA, 1'b1);
        send_word(w, 5);
        send_word(w, 5);
        wait_drained();
    endtask

    task automatic test_random();
        for (int p = 0; p < 64; p++) begin
            pool_len[p] = $urandom_range(1, 8);
            for (int j = 0; j < MAX_WORD_BYTES; j++) pool_bytes[p][j] = 8'($urandom);
        end
        for (int i = 0; i < 40; i++) begin
            int sel;
            sel = $urandom_range(0, 99);
            if (i == 20) rx_fast = 1'b1;
            if (i == 30) rx_fast = 1'b0;
            if (sel < 60) send_word(pool_bytes[$urandom_range(0, 63)],
                                    pool_len[$urandom_range(0, 63)]);
            else if (sel < 90) send_random_word(6);
            else if (sel < 98) send_random_word(MAX_WORD_BYTES + 3);
            else send_beat(OP_CLEAR, 8'($urandom), 1'($urandom));
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_rx = 1'b1;
        fork
            begin
                repeat (300) @(negedge i_clk);
                hold_rx = 1'b0;
            end
            for (int i = 0; i < 20; i++) send_random_word(3);
        join
        wait_drained();
    endtask

    task automatic test_store_full();
        logic [7:0] w [MAX_WORD_BYTES];
        gap_max = 0;
        stall_max = 0;
        send_beat(OP_CLEAR, 8'h00, 1'b0);
        for (int i = 0; i < MAX_UNIQUE + 4; i++) begin
            w[0] = 8'(i);
            w[1] = 8'(i >> 8);
            if (i < 256) send_word(w, 1);
            else send_word(w, 2);
        end
        w[0] = 8'd3;
        w[1] = 8'd0;
        send_word(w, 1);
        send_word(w, 2);
        wait_drained();
        gap_max = 15;
        stall_max = 15;
    endtask

    initial begin
        n_errors = 0;
        n_mismatch = 0;
        hold_rx = 1'b0;
        rx_fast = 1'b0;
        clear_model();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random();
        test_backpressure();
        test_store_full();
        test_random();
        wait_drained();
        if (n_errors == 0 && expected_words.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
design/sdhs_pkg.sv
design/sdhs_dpath.sv
design/sdhs_ctrl.sv
design/string_dedup_hash_set_core.sv
tb/tb_top.sv
